[rtl/ssnd_pkg.sv]
// ----------------------------------------------------------------------------
// ssnd_pkg: shared types and constants of the seven-segment number display
// operation codes, controller states, command and status bundles, helpers
// ----------------------------------------------------------------------------
package ssnd_pkg;

  // field widths fixed by the word format
  localparam int unsigned OP_W     = 2;
  localparam int unsigned POS_W    = 3;
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned SEG_W    = 8;
  localparam int unsigned NUM_W    = 16;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned CFG_A_W  = 2;
  localparam int unsigned CFG_D_W  = 64;
  localparam int unsigned IN_DW    = 32;
  localparam int unsigned OUT_DW   = 16;
  localparam int unsigned DTAB_W   = 80;

  // divide by ten through a reciprocal, exact for every 16-bit magnitude
  localparam logic [15:0] DIV10_MULT  = 16'd52429;
  localparam int unsigned DIV10_SHIFT = 19;
  localparam int unsigned QUOT_W      = 13;
  localparam logic [3:0]  DEC_RADIX   = 4'd10;

  typedef enum logic [OP_W-1:0] {
    OP_SET_PATTERN = 2'd0,
    OP_SET_INT     = 2'd1,
    OP_CLEAR       = 2'd2,
    OP_DISPLAY     = 2'd3
  } op_t;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_DIGITS_LOW  = 2'd0,
    CFG_DIGITS_HIGH = 2'd1,
    CFG_MINUS       = 2'd2,
    CFG_EMPTY       = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIGIT,
    ST_SIGN,
    ST_STATUS,
    ST_SHIFT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic exec;
    logic digit_step;
    logic sign_write;
    logic emit_status;
    logic emit_shift;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic window_ok;
    logic digit_more;
    logic neg;
    logic shift_last;
    logic out_free;
  } sts_t;

  // segment pattern of one decimal digit, digit 0 for codes above nine
  function automatic logic [SEG_W-1:0] digit_pattern(input logic [DTAB_W-1:0] tab,
                                                     input logic [3:0] d);
    logic [6:0] base;
    base = {d, 3'b000};
    if (d < DEC_RADIX) begin
      digit_pattern = tab[base +: SEG_W];
    end else begin
      digit_pattern = tab[SEG_W-1:0];
    end
  endfunction

endpackage

[rtl/ssnd_ctrl.sv]
// ----------------------------------------------------------------------------
// ssnd_ctrl: operation sequencer
// walks one item through execute, digit loop, sign, status or shift-out
// ----------------------------------------------------------------------------
module ssnd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  ssnd_pkg::sts_t  sts,
  output ssnd_pkg::cmd_t  cmd
);

  ssnd_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssnd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ssnd_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = ssnd_pkg::ST_EXEC;
      end
      ssnd_pkg::ST_EXEC: begin
        unique case (sts.op)
          ssnd_pkg::OP_SET_PATTERN,
          ssnd_pkg::OP_CLEAR:   state_nxt = ssnd_pkg::ST_STATUS;
          ssnd_pkg::OP_SET_INT: state_nxt = sts.window_ok ? ssnd_pkg::ST_DIGIT
                                                          : ssnd_pkg::ST_STATUS;
          ssnd_pkg::OP_DISPLAY: state_nxt = ssnd_pkg::ST_SHIFT;
          default:              state_nxt = ssnd_pkg::ST_STATUS;
        endcase
      end
      ssnd_pkg::ST_DIGIT: begin
        if (!sts.digit_more) begin
          state_nxt = sts.neg ? ssnd_pkg::ST_SIGN : ssnd_pkg::ST_STATUS;
        end
      end
      ssnd_pkg::ST_SIGN: begin
        state_nxt = ssnd_pkg::ST_STATUS;
      end
      ssnd_pkg::ST_STATUS: begin
        if (sts.out_free) state_nxt = ssnd_pkg::ST_IDLE;
      end
      ssnd_pkg::ST_SHIFT: begin
        if (sts.out_free && sts.shift_last) state_nxt = ssnd_pkg::ST_IDLE;
      end
      default: state_nxt = ssnd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ssnd_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.latch = in_tvalid;
      end
      ssnd_pkg::ST_EXEC:   cmd.exec        = 1'b1;
      ssnd_pkg::ST_DIGIT:  cmd.digit_step  = sts.digit_more;
      ssnd_pkg::ST_SIGN:   cmd.sign_write  = 1'b1;
      ssnd_pkg::ST_STATUS: cmd.emit_status = sts.out_free;
      ssnd_pkg::ST_SHIFT:  cmd.emit_shift  = sts.out_free;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

[rtl/ssnd_datapath.sv]
// ----------------------------------------------------------------------------
// ssnd_datapath: digit buffer, pattern registers, divide-by-ten unit
// and the output word register
// ----------------------------------------------------------------------------
module ssnd_datapath #(
  parameter int unsigned NUM_DIGITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration writes
  input  logic                          cfg_we,
  input  logic [ssnd_pkg::CFG_A_W-1:0]  cfg_addr,
  input  logic [ssnd_pkg::CFG_D_W-1:0]  cfg_wdata,
  // item fields
  input  logic [ssnd_pkg::OP_W-1:0]     op_in,
  input  logic [ssnd_pkg::POS_W-1:0]    pos_in,
  input  logic [ssnd_pkg::LEN_W-1:0]    len_in,
  input  logic [ssnd_pkg::SEG_W-1:0]    raw_in,
  input  logic [ssnd_pkg::NUM_W-1:0]    number_in,
  // controller link
  input  ssnd_pkg::cmd_t                cmd,
  output ssnd_pkg::sts_t                sts,
  // result word
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_ok,
  output logic [ssnd_pkg::SEG_W-1:0]    out_seg,
  output logic                          out_shift,
  output logic                          out_last
);

  localparam int unsigned IW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_DIGITS - 1);
  localparam logic [ssnd_pkg::POS_W+1:0] NUM_DIGITS_W = (ssnd_pkg::POS_W+2)'(NUM_DIGITS);

  // pattern registers
  logic [ssnd_pkg::CFG_D_W-1:0] dig_low_r;
  logic [15:0]                  dig_high_r;
  logic [ssnd_pkg::SEG_W-1:0]   minus_r;
  logic [ssnd_pkg::SEG_W-1:0]   empty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dig_low_r  <= '0;
      dig_high_r <= '0;
      minus_r    <= '0;
      empty_r    <= '0;
    end else if (cfg_we) begin
      unique case (ssnd_pkg::cfg_idx_t'(cfg_addr))
        ssnd_pkg::CFG_DIGITS_LOW:  dig_low_r  <= cfg_wdata;
        ssnd_pkg::CFG_DIGITS_HIGH: dig_high_r <= cfg_wdata[15:0];
        ssnd_pkg::CFG_MINUS:       minus_r    <= cfg_wdata[ssnd_pkg::SEG_W-1:0];
        ssnd_pkg::CFG_EMPTY:       empty_r    <= cfg_wdata[ssnd_pkg::SEG_W-1:0];
        default: ;
      endcase
    end
  end

  // latched item
  ssnd_pkg::op_t                op_r;
  logic [ssnd_pkg::POS_W-1:0]   pos_r;
  logic [ssnd_pkg::SEG_W-1:0]   raw_r;
  logic                         neg_r;
  logic [ssnd_pkg::NUM_W-1:0]   mag_r;
  logic [ssnd_pkg::CNT_W-1:0]   limit_r;
  logic [ssnd_pkg::CNT_W-1:0]   ct_r;
  logic [ssnd_pkg::POS_W-1:0]   ptr_r;
  logic                         win_ok_r;
  logic                         ok_r;
  logic [IW-1:0]                idx_r;

  logic                         neg_in;
  logic [ssnd_pkg::NUM_W-1:0]   mag_in;
  logic [ssnd_pkg::POS_W+1:0]   win_end;

  assign neg_in  = number_in[ssnd_pkg::NUM_W-1];
  // -32768 maps onto 0x8000, its true magnitude
  assign mag_in  = neg_in ? (~number_in + 16'd1) : number_in;
  assign win_end = (ssnd_pkg::POS_W+2)'(pos_in) + (ssnd_pkg::POS_W+2)'(len_in);

  // divide by ten: reciprocal multiply, remainder by shift-add back
  logic [31:0]                  prod;
  logic [ssnd_pkg::QUOT_W-1:0]  quot;
  logic [ssnd_pkg::NUM_W-1:0]   quot10;
  logic [ssnd_pkg::NUM_W-1:0]   rem_full;
  logic [3:0]                   rem;
  logic                         digit_more;

  assign prod     = mag_r * ssnd_pkg::DIV10_MULT;
  assign quot     = prod[ssnd_pkg::DIV10_SHIFT +: ssnd_pkg::QUOT_W];
  assign quot10   = (ssnd_pkg::NUM_W'(quot) << 3) + (ssnd_pkg::NUM_W'(quot) << 1);
  assign rem_full = mag_r - quot10;
  assign rem      = rem_full[3:0];
  // a zero magnitude still writes one digit
  assign digit_more = ((mag_r != '0) || (ct_r == '0)) && (ct_r < limit_r);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r     <= ssnd_pkg::op_t'(op_in);
      pos_r    <= pos_in;
      raw_r    <= raw_in;
      neg_r    <= neg_in;
      mag_r    <= mag_in;
      limit_r  <= len_in - ssnd_pkg::CNT_W'(neg_in);
      ct_r     <= '0;
      ptr_r    <= ssnd_pkg::POS_W'(win_end - 5'd1);
      win_ok_r <= (len_in != '0) && (win_end <= NUM_DIGITS_W);
      idx_r    <= '0;
    end else begin
      if (cmd.digit_step) begin
        mag_r <= ssnd_pkg::NUM_W'(quot);
        ct_r  <= ct_r + 4'd1;
        ptr_r <= ptr_r - 3'd1;
      end
      if (cmd.emit_shift) begin
        idx_r <= idx_r + IW'(1);
      end
    end
  end

  logic pos_ok;
  assign pos_ok = ((ssnd_pkg::POS_W+2)'(pos_r) < NUM_DIGITS_W);

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      unique case (op_r)
        ssnd_pkg::OP_SET_PATTERN: ok_r <= pos_ok;
        ssnd_pkg::OP_SET_INT:     ok_r <= win_ok_r;
        ssnd_pkg::OP_CLEAR,
        ssnd_pkg::OP_DISPLAY:     ok_r <= 1'b1;
        default:                  ok_r <= 1'b1;
      endcase
    end
  end

  // digit buffer
  logic [ssnd_pkg::SEG_W-1:0] buf_r [NUM_DIGITS];
  logic                       wr_en;
  logic [IW-1:0]              wr_addr;
  logic [ssnd_pkg::SEG_W-1:0] wr_data;
  logic                       clr;
  logic [79:0]                dig_tab;

  assign dig_tab = {dig_high_r, dig_low_r};
  assign clr     = cmd.exec && (op_r == ssnd_pkg::OP_CLEAR);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_r[IW-1:0];
    wr_data = minus_r;
    priority if (cmd.exec && (op_r == ssnd_pkg::OP_SET_PATTERN)) begin
      wr_en   = pos_ok;
      wr_addr = pos_r[IW-1:0];
      wr_data = raw_r;
    end else if (cmd.digit_step) begin
      wr_en   = 1'b1;
      wr_data = ssnd_pkg::digit_pattern(dig_tab, rem);
    end else if (cmd.sign_write) begin
      wr_en   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_DIGITS; i++) buf_r[i] <= '0;
    end else if (clr) begin
      for (int i = 0; i < NUM_DIGITS; i++) buf_r[i] <= empty_r;
    end else if (wr_en) begin
      buf_r[wr_addr] <= wr_data;
    end
  end

  // output word register
  logic                       out_valid_r;
  logic                       out_ok_r;
  logic [ssnd_pkg::SEG_W-1:0] out_seg_r;
  logic                       out_shift_r;
  logic                       out_last_r;
  logic                       out_free;
  logic                       load;

  assign out_free = !out_valid_r || out_ready;
  assign load     = cmd.emit_status || cmd.emit_shift;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ok_r    <= cmd.emit_shift ? 1'b1 : ok_r;
      out_seg_r   <= cmd.emit_shift ? buf_r[idx_r] : '0;
      out_shift_r <= cmd.emit_shift;
      out_last_r  <= cmd.emit_shift ? (idx_r == LAST_IDX) : 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_ok    = out_ok_r;
  assign out_seg   = out_seg_r;
  assign out_shift = out_shift_r;
  assign out_last  = out_last_r;

  assign sts.op         = op_r;
  assign sts.window_ok  = win_ok_r;
  assign sts.digit_more = digit_more;
  assign sts.neg        = neg_r;
  assign sts.shift_last = (idx_r == LAST_IDX);
  assign sts.out_free   = out_free;

endmodule

[rtl/seven_segment_number_display.sv]
// ----------------------------------------------------------------------------
// seven_segment_number_display: segment buffer with decimal formatting
// sequence: set pattern, clear and a rejected set integer pass execute, then emit
//   their status word; set integer writes one decimal digit per pass through the
//   shared divide-by-ten unit, then the minus sign when negative, then its status word
// display: NUM_DIGITS (8) words on consecutive cycles while the receiver is ready
// acceptance: one item at a time, the next taken only once its last word is loaded
// reset: rst_n synchronous active low, clears buffer, pattern registers, words
// ----------------------------------------------------------------------------
module seven_segment_number_display #(
  parameter int unsigned NUM_DIGITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [ssnd_pkg::CFG_A_W-1:0]  cfg_addr,
  input  logic [ssnd_pkg::CFG_D_W-1:0]  cfg_wdata,
  // input words
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // position[2:0], window_length[6:3], raw_pattern[14:7], number[30:15], zero[31]
  input  logic [ssnd_pkg::IN_DW-1:0]    in_tdata,
  // operation[1:0]
  input  logic [ssnd_pkg::OP_W-1:0]     in_tuser,
  // result words
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // ok[0], segment_byte[8:1], zero[15:9]
  output logic [ssnd_pkg::OUT_DW-1:0]   out_tdata,
  // is_shift_byte[0]
  output logic                          out_tuser,
  output logic                          out_tlast
);

  ssnd_pkg::cmd_t cmd;
  ssnd_pkg::sts_t sts;

  logic                       out_ok;
  logic [ssnd_pkg::SEG_W-1:0] out_seg;

  // sequencer: one item at a time, ready only while idle
  ssnd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // buffer, divider and output register; fields unpacked from the input word
  ssnd_datapath #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .op_in      (in_tuser),
    .pos_in     (in_tdata[2:0]),
    .len_in     (in_tdata[6:3]),
    .raw_in     (in_tdata[14:7]),
    .number_in  (in_tdata[30:15]),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_ok     (out_ok),
    .out_seg    (out_seg),
    .out_shift  (out_tuser),
    .out_last   (out_tlast)
  );

  // pack result word, upper bits zero
  assign out_tdata = {7'b0, out_seg, out_ok};

endmodule

[rtl/ssnd_checker.sv]
// ----------------------------------------------------------------------------
// ssnd_checker: port-level checks of the display block
// word format rules and one-item-at-a-time acceptance
// ----------------------------------------------------------------------------
module ssnd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [ssnd_pkg::OUT_DW-1:0] out_tdata,
  input logic                        out_tuser,
  input logic                        out_tlast
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // no second word taken right after one is accepted
  a_in_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken on consecutive cycles");

  // status word ends its operation and carries no segment byte
  a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && (out_tdata[8:1] == 8'd0))
    else $error("malformed status word");

  // shift-out words always report success
  a_shift_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[0])
    else $error("shift word without ok");

  // padding above the segment byte stays zero
  a_zero_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:9] == 7'd0))
    else $error("result word padding not zero");

endmodule

bind seven_segment_number_display ssnd_checker u_ssnd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

[verif/ssnd_word_checker.sv]
// ----------------------------------------------------------------------------
// ssnd_word_checker: result checker for the seven-segment number display
// keeps its own copy of the segment buffer and pattern registers, predicts
// the words of every accepted command and compares each returned word
// ----------------------------------------------------------------------------
module ssnd_word_checker #(
  parameter int unsigned NUM_DIGITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ssnd_pkg::CFG_A_W-1:0]  cfg_addr,
  input  logic [ssnd_pkg::CFG_D_W-1:0]  cfg_wdata,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  // position[2:0], window_length[6:3], raw_pattern[14:7], number[30:15], zero[31]
  input  logic [ssnd_pkg::IN_DW-1:0]    in_tdata,
  // operation[1:0]
  input  logic [ssnd_pkg::OP_W-1:0]     in_tuser,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  // ok[0], segment_byte[8:1], zero[15:9]
  input  logic [ssnd_pkg::OUT_DW-1:0]   out_tdata,
  // is_shift_byte[0]
  input  logic                          out_tuser,
  input  logic                          out_tlast,
  output int                            mismatches,
  output int                            words_owed
);
  import ssnd_pkg::*;

  localparam int unsigned RADIX = 10;

  typedef struct packed {
    logic             ok;
    logic [SEG_W-1:0] seg;
    logic             shift;
    logic             last;
  } seg_word_t;

  logic [SEG_W-1:0] seg_buf [NUM_DIGITS];
  logic [63:0]      digits_lo;
  logic [15:0]      digits_hi;
  logic [SEG_W-1:0] minus_seg;
  logic [SEG_W-1:0] empty_seg;
  seg_word_t        owed[$];

  function automatic logic [SEG_W-1:0] digit_seg(input int unsigned d);
    if (d < 8) return digits_lo[8*d +: 8];
    return digits_hi[8*(d-8) +: 8];
  endfunction

  // right-aligned decimal, top digits dropped when the window is too short
  task automatic format_number(input int unsigned start, input int unsigned len,
                               input logic [NUM_W-1:0] num, output logic ok);
    int unsigned mag;
    int unsigned limit;
    int unsigned ct;
    logic        neg;
    neg = num[NUM_W-1];
    mag = neg ? (32'h10000 - num) : num;
    ct  = 0;
    ok  = (len != 0) && (start + len <= NUM_DIGITS);
    if (ok) begin
      limit = neg ? len - 1 : len;
      if (mag == 0) begin
        seg_buf[start+len-1] = digit_seg(0);
        ct = 1;
      end else begin
        while (mag > 0 && ct < limit) begin
          seg_buf[start+len-1-ct] = digit_seg(mag % RADIX);
          ct++;
          mag = mag / RADIX;
        end
      end
      if (neg) seg_buf[start+len-1-ct] = minus_seg;
    end
  endtask

  task automatic apply_command(input op_t op, input logic [POS_W-1:0] pos,
                               input logic [LEN_W-1:0] len, input logic [SEG_W-1:0] raw,
                               input logic [NUM_W-1:0] num);
    logic      ok;
    seg_word_t w;
    ok = 1'b1;
    case (op)
      OP_SET_PATTERN: begin
        if (pos < NUM_DIGITS) seg_buf[pos] = raw;
        else ok = 1'b0;
      end
      OP_SET_INT: format_number(pos, len, num, ok);
      OP_CLEAR: begin
        for (int i = 0; i < NUM_DIGITS; i++) seg_buf[i] = empty_seg;
      end
      default: begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
          w.ok    = 1'b1;
          w.seg   = seg_buf[i];
          w.shift = 1'b1;
          w.last  = (i == NUM_DIGITS - 1);
          owed.push_back(w);
        end
      end
    endcase
    if (op != OP_DISPLAY) begin
      w.ok    = ok;
      w.seg   = '0;
      w.shift = 1'b0;
      w.last  = 1'b1;
      owed.push_back(w);
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned expv,
                                 input int unsigned gotv);
    $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, expv, gotv);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    seg_word_t exp_w;
    if (!rst_n) begin
      for (int i = 0; i < NUM_DIGITS; i++) seg_buf[i] = '0;
      digits_lo = '0;
      digits_hi = '0;
      minus_seg = '0;
      empty_seg = '0;
      owed.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_DIGITS_LOW:  digits_lo = cfg_wdata;
          CFG_DIGITS_HIGH: digits_hi = cfg_wdata[15:0];
          CFG_MINUS:       minus_seg = cfg_wdata[SEG_W-1:0];
          default:         empty_seg = cfg_wdata[SEG_W-1:0];
        endcase
      end
      if (in_tvalid && in_tready)
        apply_command(op_t'(in_tuser), in_tdata[2:0], in_tdata[6:3], in_tdata[14:7],
                      in_tdata[30:15]);
      if (out_tvalid && out_tready) begin
        if (owed.size() == 0) begin
          report_mismatch("unexpected word", 0, out_tdata);
        end else begin
          exp_w = owed.pop_front();
          if (out_tdata[0] !== exp_w.ok) report_mismatch("ok", exp_w.ok, out_tdata[0]);
          if (out_tdata[8:1] !== exp_w.seg)
            report_mismatch("segment byte", exp_w.seg, out_tdata[8:1]);
          if (out_tdata[15:9] !== '0) report_mismatch("zero fill", 0, out_tdata[15:9]);
          if (out_tuser !== exp_w.shift) report_mismatch("shift flag", exp_w.shift, out_tuser);
          if (out_tlast !== exp_w.last) report_mismatch("last", exp_w.last, out_tlast);
        end
      end
    end
    words_owed = owed.size();
  end

endmodule

[verif/tb_seven_segment_number_display.sv]
// ----------------------------------------------------------------------------
// tb_seven_segment_number_display: testbench of the seven-segment display
// directed commands over the corner cases of formatting, then random command
// streams under several pattern settings, with random idling on both sides
// ----------------------------------------------------------------------------
module tb_seven_segment_number_display;
  import ssnd_pkg::*;

  localparam int unsigned NUM_DIGITS   = 8;
  localparam int unsigned RANDOM_WORDS = 500;
  localparam int unsigned PHASES       = 4;
  // cycles with no handshake on either side before the run is given up
  localparam int unsigned STALL_LIMIT  = 2000;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_A_W-1:0]   cfg_addr;
  logic [CFG_D_W-1:0]   cfg_wdata;
  logic                 in_tvalid;
  logic                 in_tready;
  // position[2:0], window_length[6:3], raw_pattern[14:7], number[30:15], zero[31]
  logic [IN_DW-1:0]     in_tdata;
  // operation[1:0]
  logic [OP_W-1:0]      in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  // ok[0], segment_byte[8:1], zero[15:9]
  logic [OUT_DW-1:0]    out_tdata;
  // is_shift_byte[0]
  logic                 out_tuser;
  logic                 out_tlast;

  int                   mismatches;
  int                   words_owed;
  int unsigned          send_idle_pct;
  int unsigned          recv_stall_pct;
  int unsigned          quiet_cycles;

  seven_segment_number_display #(
    .NUM_DIGITS (NUM_DIGITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // watches both channels and the register port, hands back the error count
  ssnd_word_checker #(
    .NUM_DIGITS (NUM_DIGITS)
  ) checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .mismatches (mismatches),
    .words_owed (words_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // gap lengths: short ones in most draws, now and then a long one
  function automatic int unsigned gap_length();
    if ($urandom_range(99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // numbers: full range, two-digit values, extremes and zero, four-digit values
  function automatic logic [NUM_W-1:0] pick_number();
    int v;
    case ($urandom_range(3))
      0: return NUM_W'($urandom);
      1: begin
        v = int'($urandom_range(198)) - 99;
        return NUM_W'(v);
      end
      2: begin
        case ($urandom_range(4))
          0: return 16'h0000;
          1: return 16'h7fff;
          2: return 16'h8000;
          3: return 16'hffff;
          default: return 16'h0001;
        endcase
      end
      default: begin
        v = int'($urandom_range(9999));
        if ($urandom_range(1)) v = -v;
        return NUM_W'(v);
      end
    endcase
  endfunction

  // receiver side: random stalls of random length, set per phase
  initial begin : sink
    int unsigned hold;
    hold = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else if ($urandom_range(99) < recv_stall_pct) begin
        hold = gap_length() - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // one command word; valid stays high into the next word unless a gap is drawn
  task automatic send_word(input op_t op, input logic [POS_W-1:0] pos,
                           input logic [LEN_W-1:0] len, input logic [SEG_W-1:0] raw,
                           input logic [NUM_W-1:0] num);
    int unsigned gap;
    gap = ($urandom_range(99) < send_idle_pct) ? gap_length() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, num, raw, len, pos};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // stop sending and wait until every predicted word has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (words_owed != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_D_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  // pattern registers are only touched with the block idle
  task automatic program_patterns(input logic [CFG_D_W-1:0] lo, input logic [CFG_D_W-1:0] hi,
                                  input logic [CFG_D_W-1:0] minus,
                                  input logic [CFG_D_W-1:0] empty);
    drain();
    write_reg(CFG_DIGITS_LOW, lo);
    write_reg(CFG_DIGITS_HIGH, hi);
    write_reg(CFG_MINUS, minus);
    write_reg(CFG_EMPTY, empty);
    cfg_we <= 1'b0;
  endtask

  // mostly well-formed windows, some bad lengths and positions
  task automatic random_item();
    op_t              op;
    logic [POS_W-1:0] pos;
    logic [LEN_W-1:0] len;
    int unsigned      r;
    r  = $urandom_range(99);
    op = (r < 20) ? OP_SET_PATTERN : (r < 60) ? OP_SET_INT : (r < 75) ? OP_CLEAR : OP_DISPLAY;
    len = LEN_W'($urandom_range(1, NUM_DIGITS));
    pos = POS_W'($urandom_range(0, NUM_DIGITS - len));
    if ($urandom_range(99) < 15) begin
      len = LEN_W'($urandom_range(15));
      pos = POS_W'($urandom_range(7));
    end
    send_word(op, pos, len, SEG_W'($urandom_range(255)), pick_number());
  endtask

  // no handshake for too long means the block hung or dropped words
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_addr       = CFG_DIGITS_LOW;
    cfg_wdata      = '0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = OP_SET_PATTERN;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // buffer straight out of reset, all zero
    send_word(OP_DISPLAY, 3'd0, 4'd0, 8'h00, 16'h0000);

    // usual segment codes: digits 0..7 low, 8 and 9 high, dash, blank
    program_patterns(64'h077d6d664f5b063f, 64'h6f7f, 64'h40, 64'h00);
    send_word(OP_CLEAR, 3'd0, 4'd0, 8'h00, 16'h0000);
    send_word(OP_SET_PATTERN, 3'd0, 4'd0, 8'hff, 16'h0000);
    send_word(OP_SET_PATTERN, 3'd7, 4'd0, 8'h00, 16'h0000);
    send_word(OP_DISPLAY, 3'd0, 4'd0, 8'h00, 16'h0000);
    // largest and most negative values across the whole buffer
    send_word(OP_SET_INT, 3'd0, 4'd8, 8'h00, 16'h7fff);
    send_word(OP_DISPLAY, 3'd0, 4'd0, 8'h00, 16'h0000);
    send_word(OP_SET_INT, 3'd0, 4'd8, 8'h00, 16'h8000);
    send_word(OP_DISPLAY, 3'd0, 4'd0, 8'h00, 16'h0000);
    // zero lands in the last window slot only
    send_word(OP_CLEAR, 3'd0, 4'd0, 8'h00, 16'h0000);
    send_word(OP_SET_INT, 3'd2, 4'd3, 8'h00, 16'h0000);
    // negative in a one-digit window leaves just the dash
    send_word(OP_SET_INT, 3'd4, 4'd1, 8'h00, 16'(-5));
    // empty window, window past the end, oversized length
    send_word(OP_SET_INT, 3'd0, 4'd0, 8'h00, 16'd12);
    send_word(OP_SET_INT, 3'd5, 4'd4, 8'h00, 16'd12);
    send_word(OP_SET_INT, 3'd0, 4'd15, 8'hff, 16'hffff);
    // top digits dropped, positive and negative
    send_word(OP_SET_INT, 3'd6, 4'd2, 8'h00, 16'd12345);
    send_word(OP_SET_INT, 3'd3, 4'd3, 8'h00, 16'(-1234));
    send_word(OP_DISPLAY, 3'd0, 4'd0, 8'h00, 16'h0000);
    send_word(OP_SET_INT, 3'd7, 4'd1, 8'h00, 16'd9);
    send_word(OP_DISPLAY, 3'd0, 4'd0, 8'h00, 16'h0000);

    // random phases, each behind a full drain and a fresh register set
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          program_patterns('1, '1, '1, '1);
          send_idle_pct  = 20;
          recv_stall_pct = 20;
        end
        1: begin
          // a stretch with no idling at all
          program_patterns({$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom}, {$urandom, $urandom});
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        2: begin
          program_patterns({$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom}, {$urandom, $urandom});
          send_idle_pct  = 35;
          recv_stall_pct = 35;
        end
        default: begin
          program_patterns('0, '0, '0, '0);
          send_idle_pct  = 10;
          recv_stall_pct = 50;
        end
      endcase
      repeat (RANDOM_WORDS / PHASES) random_item();
    end

    // wait out the last words, then a short tail for stray output
    drain();
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
